>>> rtl/kwt_pkg.sv
package kwt_pkg;

    localparam int NAME_CHARS_KEPT = 8;
    localparam int BATCH_SLOTS = 3;

    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_EQUAL      = 8'h3D;
    localparam logic [7:0] CH_SEMI       = 8'h3B;
    localparam logic [7:0] CH_COMMA      = 8'h2C;

    // Keyword spellings, first character in the lowest byte, unused bytes zero.
    localparam logic [63:0] KW_FUNCTION = 64'h6E6F_6974_636E_7566;
    localparam logic [63:0] KW_IF       = 64'h0000_0000_0000_6669;
    localparam logic [63:0] KW_ELSE     = 64'h0000_0000_6573_6C65;
    localparam logic [63:0] KW_WHILE    = 64'h0000_0065_6C69_6877;
    localparam logic [63:0] KW_TRUE_LC  = 64'h0000_0000_6575_7274;
    localparam logic [63:0] KW_TRUE_UC  = 64'h0000_0000_6575_7254;
    localparam logic [63:0] KW_FALSE_LC = 64'h0000_0065_736C_6166;
    localparam logic [63:0] KW_FALSE_UC = 64'h0000_0065_736C_6146;
    localparam logic [63:0] KW_AND      = 64'h0000_0000_0064_6E61;
    localparam logic [63:0] KW_OR       = 64'h0000_0000_0000_726F;
    localparam logic [63:0] KW_NOT      = 64'h0000_0000_0074_6F6E;

    typedef enum logic [4:0] {
        K_INTEGER  = 5'd0,
        K_PLUS     = 5'd1,
        K_MINUS    = 5'd2,
        K_MUL      = 5'd3,
        K_DIV      = 5'd4,
        K_LPAREN   = 5'd5,
        K_RPAREN   = 5'd6,
        K_ID       = 5'd7,
        K_ASSIGN   = 5'd8,
        K_SEMI     = 5'd9,
        K_COMMA    = 5'd10,
        K_FUNCTION = 5'd11,
        K_IF       = 5'd12,
        K_ELSE     = 5'd13,
        K_WHILE    = 5'd14,
        K_END      = 5'd15,
        K_TRUE     = 5'd16,
        K_FALSE    = 5'd17,
        K_AND      = 5'd18,
        K_OR       = 5'd19,
        K_NOT      = 5'd20,
        K_UNKNOWN  = 5'd21
    } tok_kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_NUM  = 2'd1,
        MODE_NAME = 2'd2
    } scan_mode_t;

    typedef struct packed {
        scan_mode_t  mode;
        logic [31:0] accum;
        logic [63:0] chars;
        logic [7:0]  len;
    } lex_state_t;

    typedef struct packed {
        logic        last;
        logic [7:0]  id_length;
        logic [63:0] id_text;
        logic [31:0] int_value;
        tok_kind_t   kind;
    } tok_t;

    typedef struct packed {
        logic [1:0]                 count;
        tok_t [BATCH_SLOTS-1:0]     tok;
    } batch_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
               ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // accum * 10 + digit, saturating at the 32-bit maximum.
    function automatic logic [31:0] add_digit(input logic [31:0] accum,
                                              input logic [7:0] c);
        logic [35:0] wide;
        logic [35:0] digit;
        digit = {28'd0, c - CH_ZERO};
        wide  = ({4'd0, accum} << 3) + ({4'd0, accum} << 1) + digit;
        return (wide[35:32] != 4'd0) ? 32'hFFFF_FFFF : wide[31:0];
    endfunction

    function automatic logic [63:0] add_name_char(input logic [63:0] chars,
                                                  input logic [7:0] len,
                                                  input logic [7:0] c);
        logic [63:0] res;
        res = chars;
        for (int i = 0; i < NAME_CHARS_KEPT; i++) begin
            if (len == 8'(i)) begin
                res[8*i +: 8] = c;
            end
        end
        return res;
    endfunction

    function automatic tok_kind_t keyword_kind(input logic [63:0] chars,
                                               input logic [7:0] len);
        tok_kind_t k;
        k = K_ID;
        case (len)
            8'd2: begin
                if (chars == KW_IF) k = K_IF;
                else if (chars == KW_OR) k = K_OR;
            end
            8'd3: begin
                if (chars == KW_AND) k = K_AND;
                else if (chars == KW_NOT) k = K_NOT;
            end
            8'd4: begin
                if (chars == KW_ELSE) k = K_ELSE;
                else if (chars == KW_TRUE_LC || chars == KW_TRUE_UC) k = K_TRUE;
            end
            8'd5: begin
                if (chars == KW_WHILE) k = K_WHILE;
                else if (chars == KW_FALSE_LC || chars == KW_FALSE_UC) k = K_FALSE;
            end
            8'd8: begin
                if (chars == KW_FUNCTION) k = K_FUNCTION;
            end
            default: k = K_ID;
        endcase
        return k;
    endfunction

    function automatic tok_kind_t single_kind(input logic [7:0] c);
        tok_kind_t k;
        case (c)
            CH_PLUS:   k = K_PLUS;
            CH_MINUS:  k = K_MINUS;
            CH_STAR:   k = K_MUL;
            CH_SLASH:  k = K_DIV;
            CH_LPAREN: k = K_LPAREN;
            CH_RPAREN: k = K_RPAREN;
            CH_EQUAL:  k = K_ASSIGN;
            CH_SEMI:   k = K_SEMI;
            CH_COMMA:  k = K_COMMA;
            default:   k = K_UNKNOWN;
        endcase
        return k;
    endfunction

    // Token that a pending number or name turns into when it is closed.
    function automatic tok_t pending_tok(input lex_state_t s);
        tok_t t;
        tok_kind_t k;
        t = '0;
        k = keyword_kind(s.chars, s.len);
        if (s.mode == MODE_NUM) begin
            t.kind      = K_INTEGER;
            t.int_value = s.accum;
        end else if (k == K_ID) begin
            t.kind      = K_ID;
            t.id_text   = s.chars;
            t.id_length = s.len;
        end else begin
            t.kind = k;
        end
        return t;
    endfunction

endpackage

>>> rtl/kwt_lexer.sv
module kwt_lexer import kwt_pkg::*; (
    input  lex_state_t  st,
    input  logic [7:0]  char_code,
    input  logic        is_final,
    output lex_state_t  st_next,
    output batch_t      batch
);

    logic       digit;
    logic       alpha;
    logic       name_c;
    logic       ext_num;
    logic       ext_name;
    logic       cont;
    lex_state_t mid;

    assign digit    = is_digit(char_code);
    assign alpha    = is_alpha(char_code);
    assign name_c   = alpha || digit || (char_code == CH_UNDERSCORE);
    assign ext_num  = (st.mode == MODE_NUM) && digit;
    assign ext_name = (st.mode == MODE_NAME) && name_c;
    assign cont     = ext_num || ext_name;

    // State after the character itself, before the final flag is applied.
    always_comb begin
        mid = st;
        if (ext_num) begin
            mid.accum = add_digit(st.accum, char_code);
        end else if (ext_name) begin
            mid.chars = add_name_char(st.chars, st.len, char_code);
            mid.len   = (st.len == 8'hFF) ? st.len : st.len + 8'd1;
        end else begin
            mid = '0;
            mid.mode = MODE_IDLE;
            if (digit) begin
                mid.mode  = MODE_NUM;
                mid.accum = add_digit(32'd0, char_code);
            end else if (alpha) begin
                mid.mode  = MODE_NAME;
                mid.chars = {56'd0, char_code};
                mid.len   = 8'd1;
            end
        end
    end

    always_comb begin
        tok_t single;
        tok_t end_tok;
        logic [1:0] n;
        n = 2'd0;
        batch = '0;
        single = '0;
        single.kind = single_kind(char_code);
        end_tok = '0;
        end_tok.kind = K_END;

        if (!cont && st.mode != MODE_IDLE) begin
            batch.tok[n] = pending_tok(st);
            n = n + 2'd1;
        end
        if (!cont && !digit && !alpha && !is_space(char_code)) begin
            batch.tok[n] = single;
            n = n + 2'd1;
        end
        if (is_final && mid.mode != MODE_IDLE) begin
            batch.tok[n] = pending_tok(mid);
            n = n + 2'd1;
        end
        if (is_final) begin
            batch.tok[n] = end_tok;
            n = n + 2'd1;
        end
        if (n != 2'd0) begin
            batch.tok[n - 2'd1].last = 1'b1;
        end
        batch.count = n;
    end

    always_comb begin
        st_next = mid;
        if (is_final) begin
            st_next = '0;
            st_next.mode = MODE_IDLE;
        end
    end

endmodule

>>> rtl/kwt_outbuf.sv
module kwt_outbuf import kwt_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   load_valid,
    input  batch_t load_batch,
    output logic   load_ready,
    output logic   out_valid,
    output tok_t   out_tok,
    input  logic   out_ready
);

    tok_t [BATCH_SLOTS-1:0] slot_reg;
    logic [1:0]             count_reg;
    logic                   pop;

    assign out_valid  = (count_reg != 2'd0);
    assign out_tok    = slot_reg[0];
    assign pop        = out_valid && out_ready;
    // The buffer can take a new batch once it is empty after this cycle.
    assign load_ready = (count_reg == 2'd0) || ((count_reg == 2'd1) && out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else if (load_valid && load_ready) begin
            count_reg <= load_batch.count;
        end else if (pop) begin
            count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_valid && load_ready) begin
            slot_reg <= load_batch.tok;
        end else if (pop) begin
            slot_reg[0] <= slot_reg[1];
            slot_reg[1] <= slot_reg[2];
        end
    end

endmodule

>>> rtl/keyword_tokenizer_unit.sv
// Keyword tokenizer: turns a character stream into a token stream.
// The slave channel takes one ASCII character per transaction in s_tdata;
// s_tlast marks the last character of a text, which closes any pending
// token and appends an END token. The master channel delivers one token per
// transaction; m_tlast is set on the last token caused by a character.
// A character is held in an input register, decoded by one pass of logic
// against the scanner state, and its zero to three tokens are loaded into a
// three-entry result buffer once it can take them; the master channel is
// fed from that buffer. Throughput is one character per cycle while each
// character causes at most one token and the receiver does not stall; a
// character that causes more tokens holds the master channel for one
// transaction per token, which is what sets the rate in that case.
// When the receiver stalls, the result buffer holds its tokens and one more
// character waits in the input register; s_tready falls after that.
// Reset (aresetn low, synchronous) empties both registers and returns the
// scanner to idle with no number or name pending.
module keyword_tokenizer_unit import kwt_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] char_code
    input  logic         s_tlast,   // is_final
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // [4:0] token_kind, [36:5] int_value,
                                    // [100:37] id_text, [108:101] id_length,
                                    // [111:109] zero
    output logic         m_tlast    // run_last
);

    // Input register: one accepted character waiting to be decoded.
    logic       in_valid_reg;
    logic [7:0] char_reg;
    logic       final_reg;

    // Scanner state carried from character to character.
    lex_state_t st_reg;
    lex_state_t st_next;

    batch_t batch;
    logic   load_ready;
    logic   advance;
    tok_t   head;

    assign advance  = in_valid_reg && load_ready;
    assign s_tready = !in_valid_reg || load_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            char_reg  <= s_tdata;
            final_reg <= s_tlast;
        end
    end

    // The scanner state moves on only when the character's tokens are
    // taken by the result buffer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '{mode: MODE_IDLE, default: '0};
        end else if (advance) begin
            st_reg <= st_next;
        end
    end

    kwt_lexer u_lexer (
        .st        (st_reg),
        .char_code (char_reg),
        .is_final  (final_reg),
        .st_next   (st_next),
        .batch     (batch)
    );

    kwt_outbuf u_outbuf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_valid (in_valid_reg),
        .load_batch (batch),
        .load_ready (load_ready),
        .out_valid  (m_tvalid),
        .out_tok    (head),
        .out_ready  (m_tready)
    );

    assign m_tdata = {3'd0, head.id_length, head.id_text, head.int_value, head.kind};
    assign m_tlast = head.last;

endmodule

>>> rtl/kwt_checker.sv
module kwt_checker import kwt_pkg::*; (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [7:0]   s_tdata,
    input logic         s_tlast,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [111:0] m_tdata,
    input logic         m_tlast
);

    logic       unused_s;
    logic [4:0] kind;

    assign unused_s = s_tvalid ^ s_tready ^ s_tlast ^ (^s_tdata);
    assign kind     = m_tdata[4:0];

    // No tokens are offered right after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("token offered after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled token changed");

    // END is always the final token that its character causes.
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && kind == K_END |-> m_tlast)
        else $error("END token without tlast");

    a_int_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && kind != K_INTEGER |-> m_tdata[36:5] == 32'd0)
        else $error("integer value on a non-integer token");

    a_id_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((kind == K_ID) == (m_tdata[108:101] != 8'd0)) &&
                     (kind == K_ID || m_tdata[100:37] == 64'd0) &&
                     (m_tdata[111:109] == 3'd0) && unused_s == unused_s)
        else $error("identifier fields inconsistent with token kind");

endmodule

bind keyword_tokenizer_unit kwt_checker u_kwt_checker (.*);

>>> bench/tb_top.sv
`timescale 1ns / 100ps

// Self-checking bench for the keyword tokenizer. A scoreboard model tokenizes
// every accepted character and queues the tokens it should cause; each token
// that leaves the master channel is checked against the oldest queued one.
module tb_top;
    import kwt_pkg::*;

    localparam int RANDOM_ITEMS  = 30;
    localparam int HOLD_CYCLES   = 80;
    localparam int DRAIN_CYCLES  = 16;
    localparam int WATCHDOG_MAX  = 3000;
    localparam int MAX_PRINTS    = 50;
    localparam int LONG_NAME_LEN = 256;

    // One token as the master channel carries it.
    typedef struct packed {
        tok_kind_t   kind;
        logic [31:0] value;
        logic [63:0] text;
        logic [7:0]  length;
        logic        last;
    } token_t;

    // Tokens typed into the directed table for one character (at most two,
    // only integer values, no identifier text).
    typedef struct packed {
        bit          typed;
        logic [1:0]  count;
        tok_kind_t   kind0;
        logic [31:0] value0;
        tok_kind_t   kind1;
    } char_expect_t;

    typedef struct packed {
        logic [7:0]   code;
        logic         is_last;
        char_expect_t exp;
    } dir_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'd0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] m_tdata;
    logic         m_tlast;

    keyword_tokenizer_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Directed table. Rows with typed tokens are checked against those; the
    // rest go through the scoreboard model like the random traffic.
    dir_row_t dir_rows [24] = '{
        '{8'h00,         1'b0, '{1'b1, 2'd1, K_UNKNOWN, 32'd0, K_INTEGER}},
        '{CH_PLUS,       1'b0, '{1'b1, 2'd1, K_PLUS,    32'd0, K_INTEGER}},
        '{CH_MINUS,      1'b0, '{1'b1, 2'd1, K_MINUS,   32'd0, K_INTEGER}},
        '{CH_STAR,       1'b0, '{1'b1, 2'd1, K_MUL,     32'd0, K_INTEGER}},
        '{CH_SLASH,      1'b0, '{1'b1, 2'd1, K_DIV,     32'd0, K_INTEGER}},
        '{CH_LPAREN,     1'b0, '{1'b1, 2'd1, K_LPAREN,  32'd0, K_INTEGER}},
        '{CH_RPAREN,     1'b0, '{1'b1, 2'd1, K_RPAREN,  32'd0, K_INTEGER}},
        '{CH_EQUAL,      1'b0, '{1'b1, 2'd1, K_ASSIGN,  32'd0, K_INTEGER}},
        '{CH_SEMI,       1'b0, '{1'b1, 2'd1, K_SEMI,    32'd0, K_INTEGER}},
        '{CH_COMMA,      1'b0, '{1'b1, 2'd1, K_COMMA,   32'd0, K_INTEGER}},
        '{8'hFF,         1'b0, '{1'b1, 2'd1, K_UNKNOWN, 32'd0, K_INTEGER}},
        '{"i",           1'b0, '{1'b1, 2'd0, K_INTEGER, 32'd0, K_INTEGER}},
        '{"f",           1'b0, '{1'b1, 2'd0, K_INTEGER, 32'd0, K_INTEGER}},
        '{CH_TAB,        1'b0, '{1'b1, 2'd1, K_IF,      32'd0, K_INTEGER}},
        '{"x",           1'b0, '{1'b1, 2'd0, K_INTEGER, 32'd0, K_INTEGER}},
        '{CH_UNDERSCORE, 1'b0, '{1'b1, 2'd0, K_INTEGER, 32'd0, K_INTEGER}},
        '{"9",           1'b1, '{1'b0, 2'd0, K_INTEGER, 32'd0, K_INTEGER}},
        '{"0",           1'b0, '{1'b1, 2'd0, K_INTEGER, 32'd0, K_INTEGER}},
        '{"7",           1'b0, '{1'b1, 2'd0, K_INTEGER, 32'd0, K_INTEGER}},
        '{CH_SPACE,      1'b1, '{1'b1, 2'd2, K_INTEGER, 32'd7, K_END}},
        '{CH_CR,         1'b0, '{1'b1, 2'd0, K_INTEGER, 32'd0, K_INTEGER}},
        '{"N",           1'b0, '{1'b1, 2'd0, K_INTEGER, 32'd0, K_INTEGER}},
        '{8'h80,         1'b1, '{1'b0, 2'd0, K_INTEGER, 32'd0, K_INTEGER}},
        '{CH_SPACE,      1'b1, '{1'b1, 2'd1, K_END,     32'd0, K_INTEGER}}
    };

    string     kw_spell [11] = '{"function", "if", "else", "while", "true", "True",
                                 "false", "False", "and", "or", "not"};
    tok_kind_t kw_kind  [11] = '{K_FUNCTION, K_IF, K_ELSE, K_WHILE, K_TRUE, K_TRUE,
                                 K_FALSE, K_FALSE, K_AND, K_OR, K_NOT};

    // Scoreboard model state.
    scan_mode_t  lex_mode  = MODE_IDLE;
    logic [31:0] lex_accum = '0;
    logic [63:0] lex_chars = '0;
    logic [7:0]  lex_len   = '0;

    token_t       step_tokens[$];      // tokens caused by the character being modeled
    token_t       expected_tokens[$];  // tokens still owed by the block
    char_expect_t char_expect_q[$];    // typed expectation, one per offered character

    int mismatches = 0;
    int sent_items = 0;
    int idle_cycles = 0;
    int tx_gap_pct = 0;
    int rx_stall_pct = 0;
    bit idle_off = 1'b0;
    bit rx_hold_req = 1'b0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < MAX_PRINTS)
            $display("tb_top: mismatch on %s: got %0h, expected %0h", what, got, want);
        mismatches++;
    endtask

    task automatic emit_token(input tok_kind_t kind, input logic [31:0] value,
                              input logic [63:0] text, input logic [7:0] length);
        token_t t;
        t.kind   = kind;
        t.value  = value;
        t.text   = text;
        t.length = length;
        t.last   = 1'b0;
        step_tokens = {step_tokens, t};
    endtask

    // Identifier or one of the keywords; a keyword needs its full length.
    function automatic tok_kind_t name_kind(input logic [63:0] chars, input logic [7:0] len);
        bit hit;
        for (int i = 0; i < 11; i++) begin
            if (kw_spell[i].len() == int'(len)) begin
                hit = 1'b1;
                for (int j = 0; j < kw_spell[i].len(); j++) begin
                    if (chars[8*j +: 8] != kw_spell[i][j]) hit = 1'b0;
                end
                if (hit) return kw_kind[i];
            end
        end
        return K_ID;
    endfunction

    // Close the pending number or name, if any, and return to idle.
    task automatic close_pending();
        tok_kind_t k;
        k = name_kind(lex_chars, lex_len);
        if (lex_mode == MODE_NUM) begin
            emit_token(K_INTEGER, lex_accum, '0, '0);
        end else if (lex_mode == MODE_NAME) begin
            if (k == K_ID) emit_token(K_ID, '0, lex_chars, lex_len);
            else emit_token(k, '0, '0, '0);
        end
        lex_mode  = MODE_IDLE;
        lex_accum = '0;
        lex_chars = '0;
        lex_len   = '0;
    endtask

    task automatic append_name_char(input logic [7:0] c);
        if (lex_len < 8'(NAME_CHARS_KEPT)) lex_chars[8*lex_len +: 8] = c;
        if (lex_len != 8'hFF) lex_len = lex_len + 8'd1;
    endtask

    task automatic tokenize_char(input logic [7:0] c, input logic fin);
        logic digit, alpha, space, word;
        longint unsigned wide;
        tok_kind_t single;
        step_tokens.delete();
        digit = (c >= "0") && (c <= "9");
        alpha = ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
        space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
        word  = alpha || digit || (c == CH_UNDERSCORE);
        case (c)
            CH_PLUS:   single = K_PLUS;
            CH_MINUS:  single = K_MINUS;
            CH_STAR:   single = K_MUL;
            CH_SLASH:  single = K_DIV;
            CH_LPAREN: single = K_LPAREN;
            CH_RPAREN: single = K_RPAREN;
            CH_EQUAL:  single = K_ASSIGN;
            CH_SEMI:   single = K_SEMI;
            CH_COMMA:  single = K_COMMA;
            default:   single = K_UNKNOWN;
        endcase
        if ((lex_mode == MODE_NUM) && digit) begin
            wide = longint'(lex_accum) * 10 + longint'(c - "0");
            lex_accum = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
        end else if ((lex_mode == MODE_NAME) && word) begin
            append_name_char(c);
        end else begin
            close_pending();
            if (space) begin
                // Whitespace between tokens is dropped.
            end else if (digit) begin
                lex_mode  = MODE_NUM;
                lex_accum = 32'(c - "0");
            end else if (alpha) begin
                lex_mode = MODE_NAME;
                append_name_char(c);
            end else begin
                emit_token(single, '0, '0, '0);
            end
        end
        if (fin) begin
            close_pending();
            emit_token(K_END, '0, '0, '0);
        end
        if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
    endtask

    // Scoreboard: model every accepted character and check every token.
    always @(posedge aclk) begin : scoreboard
        char_expect_t ce;
        token_t       got;
        token_t       want;
        token_t       t;
        if (aresetn && s_tvalid && s_tready) begin
            ce = char_expect_q.pop_front();
            tokenize_char(s_tdata, s_tlast);
            if (ce.typed) begin
                for (int i = 0; i < int'(ce.count); i++) begin
                    t.kind   = (i == 0) ? ce.kind0 : ce.kind1;
                    t.value  = (i == 0) ? ce.value0 : 32'd0;
                    t.text   = '0;
                    t.length = '0;
                    t.last   = (i == int'(ce.count) - 1);
                    expected_tokens = {expected_tokens, t};
                end
            end else begin
                foreach (step_tokens[i]) expected_tokens = {expected_tokens, step_tokens[i]};
            end
        end
        if (aresetn && m_tvalid && m_tready) begin
            got.kind   = tok_kind_t'(m_tdata[4:0]);
            got.value  = m_tdata[36:5];
            got.text   = m_tdata[100:37];
            got.length = m_tdata[108:101];
            got.last   = m_tlast;
            if (expected_tokens.size() == 0) begin
                report_mismatch("unexpected token kind", 64'(got.kind), 64'd0);
            end else begin
                want = expected_tokens.pop_front();
                if (got.kind != want.kind)
                    report_mismatch("token_kind", 64'(got.kind), 64'(want.kind));
                if (got.value != want.value)
                    report_mismatch("int_value", 64'(got.value), 64'(want.value));
                if (got.text != want.text)
                    report_mismatch("id_text", got.text, want.text);
                if (got.length != want.length)
                    report_mismatch("id_length", 64'(got.length), 64'(want.length));
                if (got.last != want.last)
                    report_mismatch("run_last", 64'(got.last), 64'(want.last));
                if (m_tdata[111:109] != 3'd0)
                    report_mismatch("tdata pad bits", 64'(m_tdata[111:109]), 64'd0);
            end
        end
    end

    // Watchdog on cycles in which no transaction happens on either channel.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_MAX) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_tready <= 1'b1;
                rx_hold_req = 1'b0;
            end else if (!idle_off && ($urandom_range(99) < rx_stall_pct)) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offer one character and hold it until the block takes it.
    task automatic send_char(input logic [7:0] c, input logic fin, input char_expect_t ce);
        if (!idle_off && ($urandom_range(99) < tx_gap_pct)) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        char_expect_q = {char_expect_q, ce};
        s_tdata  <= c;
        s_tlast  <= fin;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sent_items++;
    endtask

    function automatic logic [7:0] rand_alpha();
        return ($urandom_range(1) != 0) ? 8'($urandom_range(8'h41, 8'h5A))
                                        : 8'($urandom_range(8'h61, 8'h7A));
    endfunction

    function automatic logic [7:0] rand_word_char();
        case ($urandom_range(3))
            0:       return 8'($urandom_range(8'h30, 8'h39));
            1:       return CH_UNDERSCORE;
            default: return rand_alpha();
        endcase
    endfunction

    function automatic logic [7:0] rand_operator();
        logic [7:0] ops [9] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LPAREN,
                                CH_RPAREN, CH_EQUAL, CH_SEMI, CH_COMMA};
        return ops[$urandom_range(8)];
    endfunction

    // Build one lexeme (keyword, name, number, operator or noise byte), add a
    // separator most of the time, and send it. The final flag falls anywhere.
    task automatic send_random_word();
        logic [7:0] chars[$];
        string      kw;
        int         len;
        case ($urandom_range(19))
            0, 1, 2, 3, 4, 5: begin
                kw = kw_spell[$urandom_range(10)];
                foreach (kw[i]) chars = {chars, kw[i]};
                // Near misses: an extra character, a dropped one, a case change.
                case ($urandom_range(7))
                    0: chars = {chars, rand_word_char()};
                    1: void'(chars.pop_back());
                    2: chars[0] = chars[0] ^ 8'h20;
                    default: ;
                endcase
            end
            6, 7, 8, 9: begin
                len = ($urandom_range(3) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 8);
                chars = {chars, rand_alpha()};
                for (int i = 1; i < len; i++) chars = {chars, rand_word_char()};
            end
            10, 11, 12, 13: begin
                len = ($urandom_range(3) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    chars = {chars, 8'($urandom_range(8'h30, 8'h39))};
            end
            14, 15, 16: chars = {chars, rand_operator()};
            default:    chars = {chars, 8'($urandom_range(255))};
        endcase
        if ($urandom_range(9) < 7)
            chars = {chars, (($urandom_range(2) == 0) ? 8'($urandom_range(CH_TAB, CH_CR))
                                                      : CH_SPACE)};
        foreach (chars[i]) send_char(chars[i], $urandom_range(29) == 0, '0);
    endtask

    initial begin
        int  random_end;
        bit  hold_done;
        bit  pause_done;
        int  next_shuffle;
        hold_done = 1'b0;
        pause_done = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, with moderate idling on both sides.
        tx_gap_pct   = 20;
        rx_stall_pct = 20;
        foreach (dir_rows[i]) send_char(dir_rows[i].code, dir_rows[i].is_last, dir_rows[i].exp);

        // One name long enough to saturate the length count.
        send_char("L", 1'b0, '0);
        for (int i = 1; i < LONG_NAME_LEN; i++) send_char(rand_word_char(), 1'b0, '0);
        send_char(CH_SEMI, 1'b0, '0);

        random_end   = sent_items + RANDOM_ITEMS;
        next_shuffle = sent_items;
        while (sent_items < random_end) begin
            // Change the idling mix every ten transactions; one of the
            // mixes has no idling at all.
            if (sent_items >= next_shuffle) begin
                case ($urandom_range(2))
                    0:       begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
                    1:       begin tx_gap_pct = 10; rx_stall_pct = 15; end
                    default: begin tx_gap_pct = 35; rx_stall_pct = 40; end
                endcase
                next_shuffle = sent_items + 10;
            end
            // The receiver holds off while characters keep coming, so the
            // result buffer fills and s_tready must drop.
            if (!hold_done && (sent_items >= random_end - 30)) begin
                rx_hold_req = 1'b1;
                hold_done = 1'b1;
            end
            // The sender goes quiet until every owed token has arrived.
            if (!pause_done && (sent_items >= random_end - 15)) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (expected_tokens.size() != 0) @(posedge aclk);
                repeat (8) @(posedge aclk);
                pause_done = 1'b1;
            end
            if (sent_items >= random_end - 6) idle_off = 1'b1;
            send_random_word();
        end
        // Close the text so a pending token cannot be left inside the block.
        send_char(CH_SPACE, 1'b1, '0);
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (expected_tokens.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if ((mismatches == 0) && (expected_tokens.size() == 0)) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
